// ----- src/eamb_pkg.sv -----
// Shared types, constants and helpers for the Euler affine matrix builder.
package eamb_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int QB             = ANGLE_BITS - 2;
  localparam int TW             = TRIG_FRAC_BITS + 2;
  localparam int RW             = TW + 1;
  localparam int QBITS          = 30;
  localparam int CW             = 31;
  localparam int NCF            = 6;

  localparam int ST_FRONT  = 1;
  localparam int ST_TRIG   = ST_FRONT + NCF + 2;
  localparam int ST_PAIR   = ST_TRIG + 1;
  localparam int ST_TRIPLE = ST_PAIR + 1;
  localparam int ST_SUM    = ST_TRIPLE + 1;
  localparam int ST_SCALE  = ST_SUM + 1;
  localparam int ST_OUT    = ST_SCALE + 1;
  localparam int NSTG      = ST_OUT;

  localparam int MAG_W      = 16;
  localparam int REM_W      = MAG_W + 1;
  localparam int DIV_W      = 25;
  localparam int DIV_STEP   = 3;
  localparam int DIV_NST    = (DIV_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DIV_PW     = DIV_NST * DIV_STEP;
  localparam int RCP_ONE_SH = 24;

  typedef logic [NSTG:1]          stg_en_t;
  typedef logic signed [TW-1:0]   trig_t;
  typedef logic signed [RW-1:0]   rot_t;
  typedef logic signed [31:0]     word_t;

  typedef struct packed {
    logic               opcode;
    logic [15:0]        pitch_angle;
    logic [15:0]        yaw_angle;
    logic [15:0]        roll_angle;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } eamb_in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] t_x;
    logic signed [31:0] t_y;
    logic signed [31:0] t_z;
  } eamb_out_t;

  // Q30 Taylor coefficients of the quarter-wave sine, highest order first
  function automatic logic [CW-1:0] horner_coef(input int idx);
    case (idx)
      0:       return 31'd3864;
      1:       return 31'd172272;
      2:       return 31'd5026995;
      3:       return 31'd85569306;
      4:       return 31'd693598668;
      5:       return 31'd1686629713;
      default: return '0;
    endcase
  endfunction

endpackage

// ----- src/eamb_sine.sv -----
// Pipelined quarter-wave sine evaluator, one Horner product per stage.
module eamb_sine
  import eamb_pkg::*;
(
  input  logic        clk,
  input  stg_en_t     en,
  input  logic [QB:0] xarg,
  input  logic        neg,
  output trig_t       trig
);

  localparam int SU  = ST_FRONT + 1;
  localparam int SPN = SU + NCF - 1;
  localparam int SS  = SPN + 1;
  localparam logic [CW:0] RND   = (CW + 1)'(1) << (QBITS - 1 - TRIG_FRAC_BITS);
  localparam logic [CW:0] ONE_W = (CW + 1)'(1) << TRIG_FRAC_BITS;
  localparam logic [TW-2:0] ONE = (TW - 1)'(1) << TRIG_FRAC_BITS;

  logic [QB-1:0]       x_r    [SU:SPN];
  logic                full_r [SU:SS];
  logic                neg_r  [SU:SS];
  logic [QBITS-1:0]    u2_r   [SU:SPN-1];
  logic [CW-1:0]       p_r    [SU+1:SPN];
  logic [CW-1:0]       s_r;
  trig_t               trig_r;

  logic [2*QBITS-1:0]  sq;
  logic [QBITS+CW-1:0] up;
  logic [CW-1:0]       pin    [1:NCF-1];
  logic [QBITS+CW-1:0] hp     [1:NCF-1];
  logic [CW:0]         rnd;
  logic [CW:0]         mag;
  logic [TW-2:0]       lim;
  logic signed [TW-1:0] pos;
  trig_t               trig_nxt;

  function automatic logic [QBITS-1:0] to_u(input logic [QB-1:0] x);
    return {x, {(QBITS - QB){1'b0}}};
  endfunction

  assign sq = to_u(xarg[QB-1:0]) * to_u(xarg[QB-1:0]);
  assign up = to_u(x_r[SPN]) * p_r[SPN];

  always_comb begin
    pin[1] = horner_coef(0);
    for (int j = 2; j < NCF; j++) begin
      pin[j] = p_r[SU+j-1];
    end
    for (int j = 1; j < NCF; j++) begin
      hp[j] = u2_r[SU+j-1] * pin[j];
    end
  end

  always_comb begin
    rnd = {1'b0, s_r} + RND;
    mag = rnd >> (QBITS - TRIG_FRAC_BITS);
    if (full_r[SS] || mag > ONE_W) begin
      lim = ONE;
    end else begin
      lim = mag[TW-2:0];
    end
    pos = {1'b0, lim};
    trig_nxt = neg_r[SS] ? -pos : pos;
  end

  always_ff @(posedge clk) begin
    if (en[SU]) begin
      x_r[SU]    <= xarg[QB-1:0];
      full_r[SU] <= xarg[QB];
      neg_r[SU]  <= neg;
      u2_r[SU]   <= sq[2*QBITS-1:QBITS];
    end
    for (int j = 1; j < NCF; j++) begin
      if (en[SU+j]) begin
        p_r[SU+j]    <= horner_coef(j) - hp[j][QBITS+CW-1:QBITS];
        x_r[SU+j]    <= x_r[SU+j-1];
        full_r[SU+j] <= full_r[SU+j-1];
        neg_r[SU+j]  <= neg_r[SU+j-1];
      end
    end
    for (int j = 1; j < NCF - 1; j++) begin
      if (en[SU+j]) begin
        u2_r[SU+j] <= u2_r[SU+j-1];
      end
    end
    if (en[SS]) begin
      s_r        <= up[QBITS+CW-1:QBITS];
      full_r[SS] <= full_r[SPN];
      neg_r[SS]  <= neg_r[SPN];
    end
    if (en[ST_TRIG]) begin
      trig_r <= trig_nxt;
    end
  end

  assign trig = trig_r;

endmodule

// ----- src/eamb_recip.sv -----
// Pipelined reciprocal of a Q8.8 scale, a few quotient bits per stage, or scale <<< 8 when normal is low.
module eamb_recip
  import eamb_pkg::*;
(
  input  logic                    clk,
  input  stg_en_t                 en,
  input  logic                    normal,
  input  logic signed [MAG_W-1:0] scale,
  output word_t                   k
);

  localparam int SR = ST_FRONT + DIV_NST + 1;
  localparam int SK = SR + 1;
  localparam word_t RCP_SAT = 32'sh7FFFFFFF;

  logic [REM_W-1:0]        rem_r [1:DIV_NST];
  logic [DIV_PW-1:0]       num_r [1:DIV_NST];
  logic [DIV_PW-1:0]       q_r   [1:DIV_NST];
  logic [MAG_W-1:0]        mag_r [1:DIV_NST];
  logic signed [MAG_W-1:0] sc_r  [1:DIV_NST+1];
  logic                    nrm_r [1:DIV_NST+1];
  word_t                   rcp_r;
  word_t                   k_r;

  logic [MAG_W-1:0]        mag0;
  logic [DIV_PW-1:0]       num0;
  logic [REM_W-1:0]        rin   [1:DIV_NST];
  logic [DIV_PW-1:0]       nin   [1:DIV_NST];
  logic [DIV_PW-1:0]       qin   [1:DIV_NST];
  logic [MAG_W-1:0]        mgin  [1:DIV_NST];
  logic [REM_W-1:0]        rout  [1:DIV_NST];
  logic [DIV_PW-1:0]       nout  [1:DIV_NST];
  logic [DIV_PW-1:0]       qout  [1:DIV_NST];
  word_t                   qq;
  word_t                   rcp_nxt;

  always_comb begin
    mag0 = scale[MAG_W-1] ? MAG_W'(-scale) : MAG_W'(scale);
    num0 = (DIV_PW'(1) << RCP_ONE_SH) + DIV_PW'(mag0 >> 1);
  end

  always_comb begin
    logic [REM_W-1:0]  r;
    logic [DIV_PW-1:0] n;
    logic [DIV_PW-1:0] q;
    rin[1]  = '0;
    nin[1]  = num0;
    qin[1]  = '0;
    mgin[1] = mag0;
    for (int j = 2; j <= DIV_NST; j++) begin
      rin[j]  = rem_r[j-1];
      nin[j]  = num_r[j-1];
      qin[j]  = q_r[j-1];
      mgin[j] = mag_r[j-1];
    end
    for (int j = 1; j <= DIV_NST; j++) begin
      r = rin[j];
      n = nin[j];
      q = qin[j];
      for (int b = 0; b < DIV_STEP; b++) begin
        r = {r[REM_W-2:0], n[DIV_PW-1]};
        n = {n[DIV_PW-2:0], 1'b0};
        if (r >= {1'b0, mgin[j]}) begin
          r = r - {1'b0, mgin[j]};
          q = {q[DIV_PW-2:0], 1'b1};
        end else begin
          q = {q[DIV_PW-2:0], 1'b0};
        end
      end
      rout[j] = r;
      nout[j] = n;
      qout[j] = q;
    end
  end

  always_comb begin
    qq = word_t'(q_r[DIV_NST]);
    if (mag_r[DIV_NST] == '0) begin
      rcp_nxt = RCP_SAT;
    end else if (sc_r[DIV_NST][MAG_W-1]) begin
      rcp_nxt = -qq;
    end else begin
      rcp_nxt = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_FRONT+1]) begin
      sc_r[1]  <= scale;
      nrm_r[1] <= normal;
    end
    for (int j = 1; j <= DIV_NST; j++) begin
      if (en[ST_FRONT+j]) begin
        rem_r[j] <= rout[j];
        num_r[j] <= nout[j];
        q_r[j]   <= qout[j];
        mag_r[j] <= mgin[j];
      end
    end
    for (int j = 2; j <= DIV_NST + 1; j++) begin
      if (en[ST_FRONT+j]) begin
        sc_r[j]  <= sc_r[j-1];
        nrm_r[j] <= nrm_r[j-1];
      end
    end
    if (en[SR]) begin
      rcp_r <= rcp_nxt;
    end
    if (en[SK]) begin
      k_r <= nrm_r[DIV_NST+1] ? rcp_r : (word_t'(sc_r[DIV_NST+1]) <<< 8);
    end
  end

  assign k = k_r;

endmodule

// ----- src/eamb_mat.sv -----
// Rotation products, row scaling, rounding and saturation of the 3x3 block.
module eamb_mat
  import eamb_pkg::*;
(
  input  logic  clk,
  input  stg_en_t en,
  input  trig_t s1,
  input  trig_t c1,
  input  trig_t s2,
  input  trig_t c2,
  input  trig_t s3,
  input  trig_t c3,
  input  word_t k [3],
  output word_t m [9]
);

  localparam int PW = RW + 32;
  localparam int VW = PW - TRIG_FRAC_BITS;
  localparam logic signed [2*TW-1:0] TM_HALF    = (2 * TW)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [2*TW-1:0] TM_HALF_M1 = TM_HALF - 1;
  localparam logic signed [PW-1:0]   SC_HALF    = PW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [PW-1:0]   SC_HALF_M1 = SC_HALF - 1;
  localparam logic signed [VW-1:0]   VMAX       = VW'(32'sh7FFFFFFF);
  localparam logic signed [VW-1:0]   VMIN       = VW'(32'sh80000000);

  function automatic trig_t tmul(input trig_t a, input trig_t b);
    logic signed [2*TW-1:0] p;
    p = a * b;
    p = p + (p[2*TW-1] ? TM_HALF_M1 : TM_HALF);
    return p[TRIG_FRAC_BITS+TW-1:TRIG_FRAC_BITS];
  endfunction

  function automatic word_t sround(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    logic signed [VW-1:0] v;
    s = p + (p[PW-1] ? SC_HALF_M1 : SC_HALF);
    v = s[PW-1:TRIG_FRAC_BITS];
    if (v > VMAX) begin
      return 32'sh7FFFFFFF;
    end else if (v < VMIN) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  trig_t c1c3_r, s1s2_r, c2s3_r, c1s2_r, c3s1_r, c1s3_r, c2c3_r, s1s3_r, c2s1_r, c1c2_r;
  trig_t s2_r, s3_r, c3_r, r7_r;
  trig_t tri_r [9];
  trig_t aux_r [4];
  rot_t  r_r   [9];
  logic signed [PW-1:0] p_r [9];
  word_t m_r [9];

  always_ff @(posedge clk) begin
    if (en[ST_PAIR]) begin
      c1c3_r <= tmul(c1, c3);
      s1s2_r <= tmul(s1, s2);
      c2s3_r <= tmul(c2, s3);
      c1s2_r <= tmul(c1, s2);
      c3s1_r <= tmul(c3, s1);
      c1s3_r <= tmul(c1, s3);
      c2c3_r <= tmul(c2, c3);
      s1s3_r <= tmul(s1, s3);
      c2s1_r <= tmul(c2, s1);
      c1c2_r <= tmul(c1, c2);
      s2_r   <= s2;
      s3_r   <= s3;
      c3_r   <= c3;
      r7_r   <= -s2;
    end
    if (en[ST_TRIPLE]) begin
      tri_r[0] <= tmul(s1s2_r, s3_r);
      tri_r[1] <= c2s3_r;
      tri_r[2] <= tmul(c1s2_r, s3_r);
      tri_r[3] <= tmul(s1s2_r, c3_r);
      tri_r[4] <= c2c3_r;
      tri_r[5] <= tmul(c1c3_r, s2_r);
      tri_r[6] <= c2s1_r;
      tri_r[7] <= r7_r;
      tri_r[8] <= c1c2_r;
      aux_r[0] <= c1c3_r;
      aux_r[1] <= c3s1_r;
      aux_r[2] <= c1s3_r;
      aux_r[3] <= s1s3_r;
    end
    if (en[ST_SUM]) begin
      r_r[0] <= rot_t'(tri_r[0]) + rot_t'(aux_r[0]);
      r_r[1] <= rot_t'(tri_r[1]);
      r_r[2] <= rot_t'(tri_r[2]) - rot_t'(aux_r[1]);
      r_r[3] <= rot_t'(tri_r[3]) - rot_t'(aux_r[2]);
      r_r[4] <= rot_t'(tri_r[4]);
      r_r[5] <= rot_t'(tri_r[5]) + rot_t'(aux_r[3]);
      r_r[6] <= rot_t'(tri_r[6]);
      r_r[7] <= rot_t'(tri_r[7]);
      r_r[8] <= rot_t'(tri_r[8]);
    end
    if (en[ST_SCALE]) begin
      for (int c = 0; c < 3; c++) begin
        for (int rr = 0; rr < 3; rr++) begin
          p_r[3*c+rr] <= r_r[3*c+rr] * k[c];
        end
      end
    end
    if (en[ST_OUT]) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= sround(p_r[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = m_r[i];
    end
  end

endmodule

// ----- src/euler_affine_matrix_builder.sv -----
// Top level of the Euler (YXZ) affine matrix builder.
// Takes one word per cycle while in_ready is high and returns one matrix word per
// input, in order. The pipeline is made up of the sine evaluator (one Horner product
// per stage), the trig product and scaling multipliers, and a reciprocal divider that
// retires three quotient bits per stage in parallel.
// Every stage carries its own valid bit, so an output stall backs up only into full
// stages and empty stages keep filling.
module euler_affine_matrix_builder
  import eamb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  eamb_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output eamb_out_t out_data
);

  localparam logic [ANGLE_BITS-1:0] QTR   = ANGLE_BITS'(1) << QB;
  localparam logic [QB:0]           QTR_X = (QB + 1)'(1) << QB;

  stg_en_t                 en;
  logic [NSTG:1]           v_r;

  logic [ANGLE_BITS-1:0]   base     [3];
  logic [ANGLE_BITS-1:0]   ang      [6];
  logic [QB:0]             xarg_nxt [6];
  logic                    neg_nxt  [6];

  logic [QB:0]             xarg_r   [6];
  logic                    nq_r     [6];
  logic                    op_r;
  logic signed [MAG_W-1:0] sc_r     [3];
  word_t                   t_r      [ST_FRONT:ST_OUT][3];

  trig_t                   trig     [6];
  word_t                   k        [3];
  word_t                   m        [9];

  always_comb begin
    en[NSTG] = !v_r[NSTG] || out_ready;
    for (int s = NSTG - 1; s >= 1; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int s = 2; s <= NSTG; s++) begin
        if (en[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NSTG];

  always_comb begin
    logic [QB-1:0] x;
    base[0] = in_data.yaw_angle[ANGLE_BITS-1:0];
    base[1] = in_data.pitch_angle[ANGLE_BITS-1:0];
    base[2] = in_data.roll_angle[ANGLE_BITS-1:0];
    for (int a = 0; a < 3; a++) begin
      ang[2*a]   = base[a];
      ang[2*a+1] = base[a] + QTR;
    end
    for (int l = 0; l < 6; l++) begin
      x = ang[l][QB-1:0];
      xarg_nxt[l] = ang[l][QB] ? (QTR_X - {1'b0, x}) : {1'b0, x};
      neg_nxt[l]  = ang[l][ANGLE_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_FRONT]) begin
      for (int l = 0; l < 6; l++) begin
        xarg_r[l] <= xarg_nxt[l];
        nq_r[l]   <= neg_nxt[l];
      end
      op_r  <= in_data.opcode;
      sc_r[0] <= in_data.scale_x;
      sc_r[1] <= in_data.scale_y;
      sc_r[2] <= in_data.scale_z;
      t_r[ST_FRONT][0] <= in_data.opcode ? '0 : in_data.shift_x;
      t_r[ST_FRONT][1] <= in_data.opcode ? '0 : in_data.shift_y;
      t_r[ST_FRONT][2] <= in_data.opcode ? '0 : in_data.shift_z;
    end
    for (int s = ST_FRONT + 1; s <= ST_OUT; s++) begin
      if (en[s]) begin
        for (int c = 0; c < 3; c++) begin
          t_r[s][c] <= t_r[s-1][c];
        end
      end
    end
  end

  for (genvar l = 0; l < 6; l++) begin : g_sine
    eamb_sine u_sine (
      .clk  (clk),
      .en   (en),
      .xarg (xarg_r[l]),
      .neg  (nq_r[l]),
      .trig (trig[l])
    );
  end

  for (genvar c = 0; c < 3; c++) begin : g_recip
    eamb_recip u_recip (
      .clk    (clk),
      .en     (en),
      .normal (op_r),
      .scale  (sc_r[c]),
      .k      (k[c])
    );
  end

  eamb_mat u_mat (
    .clk (clk),
    .en  (en),
    .s1  (trig[0]),
    .c1  (trig[1]),
    .s2  (trig[2]),
    .c2  (trig[3]),
    .s3  (trig[4]),
    .c3  (trig[5]),
    .k   (k),
    .m   (m)
  );

  always_comb begin
    out_data.m00 = m[0];
    out_data.m01 = m[1];
    out_data.m02 = m[2];
    out_data.m10 = m[3];
    out_data.m11 = m[4];
    out_data.m12 = m[5];
    out_data.m20 = m[6];
    out_data.m21 = m[7];
    out_data.m22 = m[8];
    out_data.t_x = t_r[ST_OUT][0];
    out_data.t_y = t_r[ST_OUT][1];
    out_data.t_z = t_r[ST_OUT][2];
  end

endmodule

// ----- test/tb.sv -----
// Testbench for the Euler affine matrix builder: predicts each matrix word and checks it.
`timescale 1ns / 1ps
module tb;
  import eamb_pkg::*;

  localparam int LIMIT_CYCLES = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  eamb_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  eamb_out_t out_data;

  eamb_out_t expected_mats[$];
  int        mismatch_cnt = 0;
  int        checked_cnt = 0;
  int        sent_cnt = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  euler_affine_matrix_builder uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint rnd_shift(longint v, int n);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (n - 1))) >>> n;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quarter_sin(int unsigned x);
    longint unsigned u, u2, p, s;
    longint unsigned coefs[5];
    coefs = '{64'd172272, 64'd5026995, 64'd85569306, 64'd693598668, 64'd1686629713};
    if (x >= (1 << 14)) return 64'sd32768;
    u = longint'(x) << 16;
    u2 = (u * u) >> 30;
    p = 64'd3864;
    for (int i = 0; i < 5; i++) p = coefs[i] - ((u2 * p) >> 30);
    s = (u * p) >> 30;
    s = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return longint'(s);
  endfunction

  function automatic longint sine_of(logic [15:0] a);
    int unsigned x;
    x = a[13:0];
    case (a[15:14])
      2'd0:    return quarter_sin(x);
      2'd1:    return quarter_sin((1 << 14) - x);
      2'd2:    return -quarter_sin(x);
      default: return -quarter_sin((1 << 14) - x);
    endcase
  endfunction

  function automatic longint tprod(longint a, longint b);
    return rnd_shift(a * b, 15);
  endfunction

  function automatic longint inv_scale(logic signed [15:0] s);
    longint unsigned m, q;
    if (s == 0) return 64'sd2147483647;
    m = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    q = ((64'd1 << 24) + (m >> 1)) / m;
    return (s < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic eamb_out_t build_matrix(eamb_in_t w);
    eamb_out_t o;
    longint c1, s1, c2, s2, c3, s3, s12, k[3], r[9];
    logic signed [31:0] e[9];
    c1 = sine_of(w.yaw_angle + 16'h4000);   s1 = sine_of(w.yaw_angle);
    c2 = sine_of(w.pitch_angle + 16'h4000); s2 = sine_of(w.pitch_angle);
    c3 = sine_of(w.roll_angle + 16'h4000);  s3 = sine_of(w.roll_angle);
    s12 = tprod(s1, s2);
    k[0] = w.opcode ? inv_scale(w.scale_x) : longint'(w.scale_x);
    k[1] = w.opcode ? inv_scale(w.scale_y) : longint'(w.scale_y);
    k[2] = w.opcode ? inv_scale(w.scale_z) : longint'(w.scale_z);
    r[0] = tprod(c1, c3) + tprod(s12, s3);
    r[1] = tprod(c2, s3);
    r[2] = tprod(tprod(c1, s2), s3) - tprod(c3, s1);
    r[3] = tprod(s12, c3) - tprod(c1, s3);
    r[4] = tprod(c2, c3);
    r[5] = tprod(tprod(c1, c3), s2) + tprod(s1, s3);
    r[6] = tprod(c2, s1);
    r[7] = -s2;
    r[8] = tprod(c1, c2);
    for (int i = 0; i < 9; i++)
      e[i] = 32'(clip32(rnd_shift(r[i] * k[i / 3], w.opcode ? 15 : 7)));
    o.m00 = e[0]; o.m01 = e[1]; o.m02 = e[2];
    o.m10 = e[3]; o.m11 = e[4]; o.m12 = e[5];
    o.m20 = e[6]; o.m21 = e[7]; o.m22 = e[8];
    o.t_x = w.opcode ? 32'sd0 : w.shift_x;
    o.t_y = w.opcode ? 32'sd0 : w.shift_y;
    o.t_z = w.opcode ? 32'sd0 : w.shift_z;
    return o;
  endfunction

  task automatic send_word(eamb_in_t w);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_mats.push_back(build_matrix(w));
    sent_cnt++;
  endtask

  function automatic eamb_in_t rand_word();
    eamb_in_t w;
    w = $bits(eamb_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom});
    case ($urandom_range(5))
      0: w.scale_x = 16'sd0;
      1: w.scale_y = 16'(-256);
      2: w.scale_z = 16'sd256;
      3: w.pitch_angle = 16'($urandom_range(3)) << 14;
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
    if (rst_n) out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_mats.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected word %h", out_data);
      end else begin
        eamb_out_t exp_m;
        exp_m = expected_mats.pop_front();
        checked_cnt++;
        if (out_data !== exp_m) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch %0d: exp %h got %h", checked_cnt, exp_m, out_data);
        end
      end
    end
  end

  task automatic test_extremes();
    eamb_in_t w;
    for (int op = 0; op < 2; op++) begin
      w = '0; w.opcode = op[0];
      w.scale_x = 16'sd256; w.scale_y = 16'sd256; w.scale_z = 16'sd256;
      for (int q = 0; q < 4; q++) begin
        w.pitch_angle = 16'(q << 14); w.yaw_angle = 16'(q * 16'h4000 + 16'h2000);
        w.roll_angle = 16'hFFFF - 16'(q);
        send_word(w);
      end
      w.scale_x = 16'sd0; w.scale_y = 16'h7FFF; w.scale_z = 16'sh8000;
      w.shift_x = 32'h7FFFFFFF; w.shift_y = 32'h80000000; w.shift_z = 32'hFFFFFFFF;
      send_word(w);
      w.scale_x = 16'sd1; w.scale_y = -16'sd1; w.scale_z = 16'sd0;
      w.pitch_angle = 16'h0000; w.yaw_angle = 16'h0000; w.roll_angle = 16'h0000;
      send_word(w);
      w.pitch_angle = 16'h1234; w.yaw_angle = 16'hFFFF; w.roll_angle = 16'h4000;
      send_word(w);
    end
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_mats.size() != 0) @(posedge clk);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      send_word(rand_word());
      if (i == n / 2) drain_wait();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    send_idle_pct = 34; recv_idle_pct = 87;
    test_random(360);
    send_idle_pct = 87; recv_idle_pct = 34;
    test_random(360);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(360);
    drain_wait();
    repeat (30) @(posedge clk);
    $display("Sent %0d words over both modes and quadrant angles, checked %0d matrices.",
             sent_cnt, checked_cnt);
    if (mismatch_cnt == 0 && expected_mats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
